// ===== src/assert_macros.svh =====
// assertion macros shared by the sixel run-length encoder modules
// expects clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked on every edge outside reset
`define SRLE_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("srle invariant violated");

// same-cycle implication
`define SRLE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("srle implication violated");

// next-cycle implication
`define SRLE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("srle next-cycle implication violated");

`endif

// ===== src/srle_pkg.sv =====
// types, constants and helpers for the sixel run-length encoder
// no dependencies; used by every module of the block
package srle_pkg;

	localparam int MAX_RUN_DEFAULT = 4096;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// run lengths up to 9999 fit in four decimal digits
	localparam int RUN_DIGITS = 4;
	localparam int BCD_W = 4 * RUN_DIGITS;

	localparam logic [7:0] SYM_OFFSET = 8'h3F;
	localparam logic [7:0] REPEAT_CHAR = 8'h21;
	localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

	typedef struct packed {
		logic [5:0] sixel_value;
		logic       band_end;
	} col_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       step_last;
		logic       band_last;
	} code_item_t;

	typedef struct packed {
		logic [5:0]       sym;
		logic [BCD_W-1:0] bcd;
	} run_t;

	// everything one accepted column asks the back end to write
	typedef struct packed {
		logic a_valid;
		run_t run_a;
		logic b_valid;
		run_t run_b;
		logic band_end;
	} cmd_t;

	function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
		logic             carry;
		logic [3:0]       d;
		logic [BCD_W-1:0] r;
		carry = 1'b1;
		r = v;
		for (int i = 0; i < RUN_DIGITS; i++) begin
			d = v[i*4 +: 4];
			if (carry) begin
				if (d == 4'd9) begin
					r[i*4 +: 4] = 4'd0;
				end else begin
					r[i*4 +: 4] = d + 4'd1;
					carry = 1'b0;
				end
			end
		end
		return r;
	endfunction

endpackage

// ===== src/srle_front.sv =====
// front end: accepts columns, tracks the open run, decides which runs close
// depends on srle_pkg and assert_macros.svh
`include "assert_macros.svh"

module srle_front #(
	parameter int MAX_RUN = srle_pkg::MAX_RUN_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                col_valid,
	output logic                col_stall,
	input  srle_pkg::col_item_t col,
	input  logic                full,
	output logic                push,
	output srle_pkg::cmd_t      cmd
);
	import srle_pkg::*;

	localparam int LEN_W = $clog2(MAX_RUN + 1);

	logic [5:0]       sym_q;
	logic [LEN_W-1:0] len_q;
	logic [BCD_W-1:0] bcd_q;

	logic             acc;
	logic             open;
	logic             change;
	logic             extend;
	logic [LEN_W-1:0] new_len;
	logic [BCD_W-1:0] new_bcd;
	logic             max_hit;

	assign col_stall = full;
	assign acc = col_valid && !col_stall;
	assign open = (len_q != '0);
	assign change = open && (col.sixel_value != sym_q);
	assign extend = open && !change;
	assign new_len = extend ? len_q + LEN_W'(1) : LEN_W'(1);
	assign new_bcd = extend ? bcd_inc(bcd_q) : BCD_W'(1);
	assign max_hit = (new_len == LEN_W'(MAX_RUN));

	always_comb begin
		cmd.a_valid = change;
		cmd.run_a.sym = sym_q;
		cmd.run_a.bcd = bcd_q;
		cmd.b_valid = max_hit || col.band_end;
		cmd.run_b.sym = col.sixel_value;
		cmd.run_b.bcd = new_bcd;
		cmd.band_end = col.band_end;
	end

	assign push = acc && (cmd.a_valid || cmd.b_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q <= '0;
			len_q <= '0;
			bcd_q <= '0;
		end else if (acc) begin
			sym_q <= col.sixel_value;
			if (cmd.b_valid) begin
				len_q <= '0;
				bcd_q <= '0;
			end else begin
				len_q <= new_len;
				bcd_q <= new_bcd;
			end
		end
	end

	`SRLE_ASSERT(a_len_below_max, len_q < LEN_W'(MAX_RUN))
	`SRLE_ASSERT_NEXT(a_band_end_closes, acc && col.band_end, len_q == '0)
	`SRLE_ASSERT_IMP(a_change_writes_old_run, acc && change, push && cmd.a_valid)

endmodule

// ===== src/srle_queue.sv =====
// short command queue between front and back ends
// depends on srle_pkg and assert_macros.svh
`include "assert_macros.svh"

module srle_queue #(
	parameter int DEPTH = srle_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  srle_pkg::cmd_t wr_data,
	output logic           full,
	output logic           rd_valid,
	output srle_pkg::cmd_t rd_data,
	input  logic           rd_en
);
	import srle_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign full = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`SRLE_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH))
	`SRLE_ASSERT_IMP(a_no_overflow, wr_en, !full)
	`SRLE_ASSERT_IMP(a_no_underflow, rd_en, rd_valid)

endmodule

// ===== src/srle_back.sv =====
// back end: turns queued run commands into ascii bytes, one per cycle while code_stall is low
// depends on srle_pkg and assert_macros.svh
`include "assert_macros.svh"

module srle_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  srle_pkg::cmd_t       cmd,
	output logic                 cmd_pop,
	output logic                 code_valid,
	input  logic                 code_stall,
	output srle_pkg::code_item_t code
);
	import srle_pkg::*;

	cmd_t       ent_q;
	logic       ent_valid_q;
	logic       sel_q;
	logic [2:0] pos_q;
	logic       code_valid_q;
	code_item_t code_q;

	run_t       r;
	logic [3:0] d3, d2, d1, d0;
	logic       long_run;
	logic [2:0] nd;
	logic [2:0] dsel;
	logic [3:0] digit;
	logic [7:0] ch;
	logic [7:0] out_char;
	logic       run_end;
	logic       ent_end;
	logic       advance;
	logic       emit;
	logic       load;

	always_comb begin
		r = sel_q ? ent_q.run_b : ent_q.run_a;
		d3 = r.bcd[15:12];
		d2 = r.bcd[11:8];
		d1 = r.bcd[7:4];
		d0 = r.bcd[3:0];
		long_run = (d3 != 4'd0) || (d2 != 4'd0) || (d1 != 4'd0) || (d0 >= 4'd4);
		if (d3 != 4'd0) begin
			nd = 3'd4;
		end else if (d2 != 4'd0) begin
			nd = 3'd3;
		end else if (d1 != 4'd0) begin
			nd = 3'd2;
		end else begin
			nd = 3'd1;
		end
		dsel = nd - pos_q;
		digit = r.bcd[{dsel[1:0], 2'b00} +: 4];
		ch = {2'b00, r.sym} + SYM_OFFSET;
		if (!long_run) begin
			out_char = ch;
			run_end = (pos_q == ({1'b0, d0[1:0]} - 3'd1));
		end else if (pos_q == 3'd0) begin
			out_char = REPEAT_CHAR;
			run_end = 1'b0;
		end else if (pos_q == nd + 3'd1) begin
			out_char = ch;
			run_end = 1'b1;
		end else begin
			out_char = {ASCII_DIGIT_HI, digit};
			run_end = 1'b0;
		end
		ent_end = run_end && (sel_q || !ent_q.b_valid);
	end

	assign advance = !code_valid_q || !code_stall;
	assign emit = advance && ent_valid_q;
	assign load = !ent_valid_q || (emit && ent_end);
	assign cmd_pop = load && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
			sel_q <= 1'b0;
			pos_q <= '0;
			code_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				code_valid_q <= 1'b1;
			end else if (advance) begin
				code_valid_q <= 1'b0;
			end
			if (cmd_pop) begin
				ent_valid_q <= 1'b1;
				sel_q <= !cmd.a_valid;
				pos_q <= '0;
			end else if (emit && ent_end) begin
				ent_valid_q <= 1'b0;
			end else if (emit && run_end) begin
				sel_q <= 1'b1;
				pos_q <= '0;
			end else if (emit) begin
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			ent_q <= cmd;
		end
		if (emit) begin
			code_q.out_byte <= out_char;
			code_q.step_last <= ent_end;
			code_q.band_last <= ent_end && ent_q.band_end;
		end
	end

	assign code_valid = code_valid_q;
	assign code = code_q;

	`SRLE_ASSERT_IMP(a_band_last_ends_step, code_valid_q && code_q.band_last, code_q.step_last)
	`SRLE_ASSERT(a_entry_has_run, !ent_valid_q || ent_q.a_valid || ent_q.b_valid)
	`SRLE_ASSERT_IMP(a_pos_bound, ent_valid_q, pos_q <= 3'd5)

endmodule

// ===== src/sixel_run_length_encoder.sv =====
// Sixel run-length encoder: takes one 6-bit sixel column per transfer and writes the
// encoded band as ASCII bytes, one byte per transfer on the code channel. A column is
// accepted every cycle while the command queue (QUEUE_DEPTH entries) has room; columns
// that only extend a run write nothing. A run of n >= 4 columns is written as '!',
// digits(n) digit bytes and the value plus 0x3F, that is 2 + digits(n) bytes from the byte
// writer; shorter runs take n bytes. The byte writer, at one byte per cycle while
// code_stall is low, sets the sustained rate whenever the band averages more than one
// byte per column. With the queue empty, the command closing a run passes through
// the queue, the entry register and the byte register before the first byte is
// presented. Runs that reach MAX_RUN are written out at once and a fresh run begins.
// depends on srle_pkg and the srle_front, srle_queue and srle_back modules
module sixel_run_length_encoder #(
	parameter int MAX_RUN = srle_pkg::MAX_RUN_DEFAULT,
	parameter int QUEUE_DEPTH = srle_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 col_valid,
	output logic                 col_stall,
	input  srle_pkg::col_item_t  col,
	output logic                 code_valid,
	input  logic                 code_stall,
	output srle_pkg::code_item_t code
);
	import srle_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic full;
	logic q_valid;
	cmd_t q_cmd;
	logic q_pop;

	srle_front #(
		.MAX_RUN(MAX_RUN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.col_valid(col_valid),
		.col_stall(col_stall),
		.col(col),
		.full(full),
		.push(push),
		.cmd(push_cmd)
	);

	srle_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push),
		.wr_data(push_cmd),
		.full(full),
		.rd_valid(q_valid),
		.rd_data(q_cmd),
		.rd_en(q_pop)
	);

	srle_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(q_valid),
		.cmd(q_cmd),
		.cmd_pop(q_pop),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code(code)
	);

endmodule
